// File: rtl/frkvc_pkg.sv
// Shared types and constants for the FIFO-replacement key-value cache.
// No dependencies; the other files that use it refer to it by scoped names.
package frkvc_pkg;

  // Key width and configuration register width
  localparam int unsigned KEY_W = 32;
  localparam int unsigned CAP_W = 4;

  // Capacity after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 4'd5;

  // Operation codes carried in the func field
  typedef enum logic {
    FUNC_PUT = 1'b0,
    FUNC_GET = 1'b1
  } func_t;

  // Per-cell control from the top-level sequencing logic
  typedef struct packed {
    logic shift;  // take the neighbour's entry (oldest drops out)
    logic load;   // write the incoming key and value as a new entry
    logic upd;    // overwrite the value of a matching entry
  } cell_ctrl_t;

endpackage

// File: rtl/frkvc_in_if.sv
// Request channel interface: valid/ready handshake with func, key and value.
// Depends on frkvc_pkg for the key width.
interface frkvc_in_if #(
  parameter int unsigned VALUE_BITS = 64
);
  logic                             valid;
  logic                             ready;
  logic                             func;
  logic signed [frkvc_pkg::KEY_W-1:0] key;
  logic [VALUE_BITS-1:0]            value;

  modport source (output valid, output func, output key, output value, input ready);
  modport sink   (input valid, input func, input key, input value, output ready);
endinterface

// File: rtl/frkvc_out_if.sv
// Result channel interface: valid/ready handshake with found, read_value, evicted.
// No package dependencies.
interface frkvc_out_if #(
  parameter int unsigned VALUE_BITS = 64
);
  logic                  valid;
  logic                  ready;
  logic                  found;
  logic [VALUE_BITS-1:0] read_value;
  logic                  evicted;

  modport source (output valid, output found, output read_value, output evicted,
                  input ready);
  modport sink   (input valid, input found, input read_value, input evicted,
                  output ready);
endinterface

// File: rtl/frkvc_cfg_if.sv
// Configuration write channel interface: valid/ready with the capacity word.
// Depends on frkvc_pkg for the register width.
interface frkvc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [frkvc_pkg::CAP_W-1:0]    data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/frkvc_cell.sv
// One storage cell of the cache row: key, value and valid bit, key compare,
// and a shift path from the younger neighbour. Depends on frkvc_pkg.
module frkvc_cell #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  frkvc_pkg::cell_ctrl_t                ctrl,
  input  logic signed [frkvc_pkg::KEY_W-1:0]   req_key,
  input  logic [VALUE_BITS-1:0]                req_value,
  input  logic                                 nb_valid,
  input  logic signed [frkvc_pkg::KEY_W-1:0]   nb_key,
  input  logic [VALUE_BITS-1:0]                nb_value,
  output logic                                 valid,
  output logic signed [frkvc_pkg::KEY_W-1:0]   key,
  output logic [VALUE_BITS-1:0]                value,
  output logic                                 hit
);

  logic                               valid_r, valid_nxt;
  logic signed [frkvc_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [VALUE_BITS-1:0]              value_r, value_nxt;

  // Compare the request key against the held entry
  assign hit = valid_r && (key_r == req_key);

  // Select next contents: new entry wins over shift, shift over update
  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    if (ctrl.load) begin
      valid_nxt = 1'b1;
      key_nxt   = req_key;
      value_nxt = req_value;
    end else if (ctrl.shift) begin
      valid_nxt = nb_valid;
      key_nxt   = nb_key;
      value_nxt = nb_value;
    end else if (ctrl.upd) begin
      value_nxt = req_value;
    end
  end

  // Hold the valid bit under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

  assign valid = valid_r;
  assign key   = key_r;
  assign value = value_r;

endmodule

// File: rtl/fifo_replacement_key_value_cache.sv
// Fully associative key-value cache with first-in-first-out replacement.
// Uses frkvc_pkg, the three channel interfaces and frkvc_cell.
//
// Usage:
//   in_if   : request beats (func put/get, signed 32-bit key, value word).
//   out_if  : one result beat per request (found, read_value, evicted).
//   cfg_if  : write beat setting the capacity (0 acts as 1, values above
//             MAX_ENTRIES act as MAX_ENTRIES). Write only while idle.
// The entries sit in a row of MAX_ENTRIES cells in age order, oldest in
// cell 0. Every cell compares its key in parallel; a put of a new key
// writes the cell after the youngest, or, when the cache is full, shifts
// the whole row one cell towards cell 0 so the oldest drops out and the
// new entry lands at the tail.
// Result: the result beat comes from an output register and is valid in the cycle after the request beat.
// Throughput: one request per cycle while the output register is free or draining; the key
// compare is combinational and the cell update is registered.
// Stall: a result waits in the output register; a new request is taken
// in the same cycle the waiting result leaves, otherwise in_if.ready drops.
// Reset: synchronous, active low; the cache empties and capacity returns
// to 5. No clearing pass is needed.
module fifo_replacement_key_value_cache #(
  parameter int unsigned MAX_ENTRIES = 8,
  parameter int unsigned VALUE_BITS  = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  frkvc_in_if.sink      in_if,
  frkvc_out_if.source   out_if,
  frkvc_cfg_if.sink     cfg_if
);

  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned EFF_W = (CNT_W > frkvc_pkg::CAP_W) ? CNT_W : frkvc_pkg::CAP_W;

  logic [frkvc_pkg::CAP_W-1:0] cap_r, cap_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        found_r, found_nxt;
  logic [VALUE_BITS-1:0]       rd_value_r, rd_value_nxt;
  logic                        evicted_r, evicted_nxt;

  logic                               valid_vec [MAX_ENTRIES];
  logic signed [frkvc_pkg::KEY_W-1:0] key_vec   [MAX_ENTRIES];
  logic [VALUE_BITS-1:0]              value_vec [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]             hit_vec;
  frkvc_pkg::cell_ctrl_t              ctrl_vec  [MAX_ENTRIES];

  logic                  accept;
  logic                  is_put;
  logic                  any_hit;
  logic                  do_evict;
  logic                  miss_put;
  logic [EFF_W-1:0]      cap_ext;
  logic [EFF_W-1:0]      eff_cap;
  logic [CNT_W-1:0]      slot_cnt;
  logic [IDX_W-1:0]      slot_idx;
  logic [VALUE_BITS-1:0] hit_value;
  logic [MAX_ENTRIES-1:0] valid_bits;

  // Handshake: take a request when the output register is free or draining
  assign in_if.ready  = !out_valid_r || out_if.ready;
  assign accept       = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  // Clamp the capacity to 1..MAX_ENTRIES
  always_comb begin
    cap_ext = EFF_W'(cap_r);
    if (cap_r == '0) begin
      eff_cap = EFF_W'(1);
    end else if (cap_ext > EFF_W'(MAX_ENTRIES)) begin
      eff_cap = EFF_W'(MAX_ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  // Decode the request against the hit vector
  assign is_put   = (in_if.func == frkvc_pkg::FUNC_PUT);
  assign any_hit  = |hit_vec;
  assign miss_put = is_put && !any_hit;
  assign do_evict = miss_put && (EFF_W'(count_r) >= eff_cap) && (count_r != '0);
  assign slot_cnt = do_evict ? (count_r - CNT_W'(1)) : count_r;
  assign slot_idx = slot_cnt[IDX_W-1:0];

  // Gather the value of the matching cell
  always_comb begin
    hit_value = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (hit_vec[i]) begin
        hit_value = hit_value | value_vec[i];
      end
    end
  end

  // Build the row of cells, each fed by its younger neighbour
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    logic                               nb_valid;
    logic signed [frkvc_pkg::KEY_W-1:0] nb_key;
    logic [VALUE_BITS-1:0]              nb_value;

    if (g + 1 < MAX_ENTRIES) begin : g_nb
      assign nb_valid = valid_vec[g+1];
      assign nb_key   = key_vec[g+1];
      assign nb_value = value_vec[g+1];
    end else begin : g_tail
      assign nb_valid = 1'b0;
      assign nb_key   = '0;
      assign nb_value = '0;
    end

    assign ctrl_vec[g].shift = accept && do_evict;
    assign ctrl_vec[g].load  = accept && miss_put && (slot_idx == IDX_W'(g));
    assign ctrl_vec[g].upd   = accept && is_put && hit_vec[g];
    assign valid_bits[g]     = valid_vec[g];

    frkvc_cell #(
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl_vec[g]),
      .req_key   (in_if.key),
      .req_value (in_if.value),
      .nb_valid  (nb_valid),
      .nb_key    (nb_key),
      .nb_value  (nb_value),
      .valid     (valid_vec[g]),
      .key       (key_vec[g]),
      .value     (value_vec[g]),
      .hit       (hit_vec[g])
    );
  end

  // Next state for count, capacity and the output register
  always_comb begin
    cap_nxt       = cap_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    found_nxt     = found_r;
    rd_value_nxt  = rd_value_r;
    evicted_nxt   = evicted_r;
    if (cfg_if.valid && cfg_if.ready) begin
      cap_nxt = cfg_if.data;
    end
    if (accept && miss_put && !do_evict) begin
      count_nxt = count_r + CNT_W'(1);
    end
    if (accept) begin
      out_valid_nxt = 1'b1;
      found_nxt     = any_hit;
      rd_value_nxt  = (!is_put && any_hit) ? hit_value : '0;
      evicted_nxt   = do_evict;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= frkvc_pkg::CAP_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cap_r       <= cap_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    found_r    <= found_nxt;
    rd_value_r <= rd_value_nxt;
    evicted_r  <= evicted_nxt;
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.found      = found_r;
  assign out_if.read_value = rd_value_r;
  assign out_if.evicted    = evicted_r;

  // Keys are unique, so at most one cell matches
  a_hit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_vec))
    else $error("more than one cell matched the request key");

  // The fill count tracks the number of valid cells
  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_bits) == 32'(count_r))
    else $error("entry count differs from valid cells");

  // An eviction replaces one entry and leaves the count unchanged
  a_evict_count: assert property (@(posedge clk) disable iff (!rst_n)
    accept && do_evict |=> $stable(count_r))
    else $error("eviction changed the entry count");

  // A get never changes the fill count
  a_get_count: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !is_put |=> $stable(count_r))
    else $error("get changed the entry count");

  // Eviction only occurs with the cache non-empty
  a_evict_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    do_evict |-> (count_r != '0) && miss_put)
    else $error("eviction on empty cache or non-miss put");

endmodule
